### design/sshrm_pkg.sv
// Package for the seeded string hash core: word width, mix constants,
// the item type carried from the byte front end to the mix pipeline,
// and small combinational helpers. No dependencies.
package sshrm_pkg;

    localparam int WORD_BITS   = 64;
    localparam int SEED_BITS   = 64;
    localparam int BYTE_BITS   = 8;
    localparam int HASH_BITS   = 64;
    localparam int HALF_BITS   = WORD_BITS / 2;
    localparam int HIGH_BITS   = WORD_BITS - HALF_BITS;
    localparam int ROT_BITS    = 9;
    localparam int MULT_BITS   = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    localparam logic [MULT_BITS-1:0] MIX_MULT    = 32'h27d4eb2d;
    localparam logic [WORD_BITS-1:0] MIX_XOR     = WORD_BITS'(61);
    localparam int                   MIX_SHIFT_A = 16;
    localparam int                   MIX_SHIFT_B = 3;
    localparam int                   MIX_SHIFT_C = 4;
    localparam int                   MIX_SHIFT_D = 15;

    typedef logic [WORD_BITS-1:0] word_t;

    // One finished string on its way to the mix: accumulator already XORed
    // with the seed, plus the seed to add at the end.
    typedef struct packed {
        word_t mixed_in;
        word_t seed;
    } mix_item_t;

    typedef struct packed {
        logic not_empty;
        logic not_full;
    } queue_status_t;

    function automatic word_t rotl9(input word_t v);
        return {v[WORD_BITS-ROT_BITS-1:0], v[WORD_BITS-1:WORD_BITS-ROT_BITS]};
    endfunction

    // Mix steps ahead of the multiply.
    function automatic word_t premix(input word_t h);
        word_t a;
        word_t b;
        a = (h ^ MIX_XOR) ^ (h >> MIX_SHIFT_A);
        b = a + (a << MIX_SHIFT_B);
        return b ^ (b >> MIX_SHIFT_C);
    endfunction

endpackage

### design/sshrm_front.sv
// Byte front end: keeps the running word, rotates and adds each nonzero
// byte, and pushes a mix item into the queue on the terminating zero byte.
// Depends on sshrm_pkg.
module sshrm_front
    import sshrm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [BYTE_BITS-1:0] text_byte,
    input  word_t                seed,
    input  queue_status_t        q_status,
    output logic                 push,
    output mix_item_t            push_item
);

    logic  inside_reg;
    logic  inside_next;
    word_t acc_reg;
    word_t acc_next;
    word_t base;
    logic  accept;

    assign in_ready = q_status.not_full;
    assign accept   = in_valid && in_ready;

    // A byte that opens a string starts from the current seed.
    assign base = inside_reg ? acc_reg : seed;

    assign push               = accept && (text_byte == '0);
    assign push_item.mixed_in = base ^ seed;
    assign push_item.seed     = seed;

    always_comb
    begin
        inside_next = inside_reg;
        acc_next    = acc_reg;
        if (accept)
        begin
            if (text_byte != '0)
            begin
                inside_next = 1'b1;
                acc_next    = rotl9(base) + WORD_BITS'(text_byte);
            end
            else
            begin
                inside_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg <= 1'b0;
        end
        else
        begin
            inside_reg <= inside_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

endmodule

### design/sshrm_queue.sv
// Short queue between the byte front end and the mix pipeline, so that a
// stalled output does not hold up the byte stream. Depends on sshrm_pkg.
module sshrm_queue
    import sshrm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mix_item_t     push_item,
    input  logic          pop,
    output mix_item_t     head_item,
    output queue_status_t q_status
);

    mix_item_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg;
    logic [QPTR_BITS-1:0]   wr_ptr_next;
    logic [QPTR_BITS-1:0]   rd_ptr_reg;
    logic [QPTR_BITS-1:0]   rd_ptr_next;
    logic [QPTR_BITS:0]     count_reg;
    logic [QPTR_BITS:0]     count_next;
    logic                   do_push;
    logic                   do_pop;

    assign q_status.not_empty = (count_reg != '0);
    assign q_status.not_full  = (count_reg != (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign do_push            = push && q_status.not_full;
    assign do_pop             = pop && q_status.not_empty;
    assign head_item          = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### design/sshrm_back.sv
// Mix pipeline: four stages of the shift-multiply mix and the final seed
// add, the last stage being the output register. Depends on sshrm_pkg.
module sshrm_back
    import sshrm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  queue_status_t        q_status,
    input  mix_item_t            head_item,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [HASH_BITS-1:0] hash_value
);

    logic  s1_valid_reg;
    logic  s2_valid_reg;
    logic  s3_valid_reg;
    logic  s4_valid_reg;
    logic  advance;

    word_t s1_h_reg;
    word_t s1_seed_reg;
    word_t s2_lo_reg;
    logic [HIGH_BITS-1:0] s2_hi_reg;
    word_t s2_seed_reg;
    word_t s3_h_reg;
    word_t s3_seed_reg;
    word_t s4_hash_reg;

    logic [HALF_BITS+MULT_BITS-1:0] lo_prod;
    logic [HIGH_BITS-1:0]           hi_prod;
    word_t                          mul_sum;

    // The whole pipeline moves together unless a result waits at the output.
    assign advance = !s4_valid_reg || out_ready;
    assign pop     = advance && q_status.not_empty;

    // The product modulo the word is split into two narrow partial products.
    assign lo_prod = s1_h_reg[HALF_BITS-1:0] * MIX_MULT;
    assign hi_prod = s1_h_reg[WORD_BITS-1:HALF_BITS] * MIX_MULT[HIGH_BITS-1:0];
    assign mul_sum = s2_lo_reg + {s2_hi_reg, HALF_BITS'(0)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= q_status.not_empty;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_h_reg    <= premix(head_item.mixed_in);
            s1_seed_reg <= head_item.seed;
            s2_lo_reg   <= WORD_BITS'(lo_prod);
            s2_hi_reg   <= hi_prod;
            s2_seed_reg <= s1_seed_reg;
            s3_h_reg    <= mul_sum ^ (mul_sum >> MIX_SHIFT_D);
            s3_seed_reg <= s2_seed_reg;
            s4_hash_reg <= s3_h_reg + s3_seed_reg;
        end
    end

    assign out_valid  = s4_valid_reg;
    assign hash_value = HASH_BITS'(s4_hash_reg);

endmodule

### design/seeded_string_hash_rotate_mix_core.sv
// Seeded string hash core: byte front end, item queue and mix pipeline.
// Accepts one byte per cycle while the queue has room; a zero byte ends the string and yields the hash.
// After the zero byte is taken, its item enters the queue and, with an idle output, passes
// the four mix stages to hash_value; throughput is one byte per cycle while the queue has
// room, set by the rotate-and-add that updates the accumulator register on each accepted byte.
// Reset clears the seed to zero, the string-in-progress flag, queue and stages.
module seeded_string_hash_rotate_mix_core
    import sshrm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [SEED_BITS-1:0] cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [BYTE_BITS-1:0] text_byte,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [HASH_BITS-1:0] hash_value
);

    logic [SEED_BITS-1:0] seed_reg;
    word_t                seed;
    queue_status_t        q_status;
    logic                 push;
    logic                 pop;
    mix_item_t            push_item;
    mix_item_t            head_item;

    assign cfg_ready = 1'b1;
    assign seed      = seed_reg[WORD_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            seed_reg <= cfg_data;
        end
    end

    sshrm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .text_byte (text_byte),
        .seed      (seed),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    sshrm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .q_status  (q_status)
    );

    sshrm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .head_item  (head_item),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hash_value (hash_value)
    );

endmodule

### design/sshrm_checker.sv
// Port-level checker for the seeded string hash core, bound to the top level.
// Depends on sshrm_pkg for port widths.
module sshrm_checker
    import sshrm_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 cfg_ready,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [HASH_BITS-1:0] hash_value
);

    // A waiting result holds its value until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hash_value))
        else $error("result item changed or dropped while stalled");

    // Nothing comes out in the first cycle after reset is released.
    a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !out_valid)
        else $error("result item right after reset");

    // The queue fills only while the output is blocked.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled without a pending result item");

    a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("seed write refused");

endmodule

bind seeded_string_hash_rotate_mix_core sshrm_checker u_sshrm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_ready  (cfg_ready),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hash_value (hash_value)
);

### sim/seeded_string_hash_rotate_mix_core_test.sv
// Self-checking testbench for seeded_string_hash_rotate_mix_core: a directed table, then
// random strings under fixed, then random seeds, checked against a local hash predictor.
// Depends on sshrm_pkg and the core RTL only.
`timescale 1ns / 1ps

module seeded_string_hash_rotate_mix_core_test;
    import sshrm_pkg::*;

    localparam int    RANDOM_ITEMS  = 1650;
    localparam int    PHASE_ITEMS   = 150;
    localparam int    SETTLE_CYCLES = 8;
    localparam int    LONG_HOLD     = 300;
    localparam int    REPORT_LIMIT  = 10;
    localparam word_t NO_SEED_EMPTY_HASH   = 64'h0000_0050_C009_496A;
    localparam word_t ONES_SEED_EMPTY_HASH = 64'h0000_0050_C009_4969;

    typedef enum logic {ROW_BYTE, ROW_SEED} row_kind_t;

    typedef struct {
        row_kind_t kind;
        word_t     value;
        bit        checked;
        word_t     hash;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [SEED_BITS-1:0] cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [BYTE_BITS-1:0] text_byte;
    logic                 out_valid;
    logic                 out_ready;
    logic [HASH_BITS-1:0] hash_value;

    // Predictor state.
    word_t seed_shadow;
    word_t acc_word;
    bit    in_string;

    word_t       expected_hashes[$];
    stim_row_t   directed_rows[$];
    int unsigned fail_count;
    int unsigned items_sent;
    int unsigned send_calm;
    int unsigned recv_calm;
    int unsigned recv_hold;
    bit          long_hold;
    word_t       recv_want;
    word_t       row_hash;
    int unsigned phase;
    int unsigned phase_start;
    int unsigned len_pick;
    word_t       phase_seed;

    seeded_string_hash_rotate_mix_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .text_byte  (text_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hash_value (hash_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(64'd8_000_000);
        $display("** seeded_string_hash_rotate_mix_core: FAILED **");
        $finish;
    end

    function automatic word_t shift_mult_mix(input word_t h);
        word_t x;
        x = (h ^ word_t'(61)) ^ (h >> 16);
        x = x + (x << 3);
        x = x ^ (x >> 4);
        x = x * word_t'(32'h27d4eb2d);
        x = x ^ (x >> 15);
        return x;
    endfunction

    // Advances the predictor by one accepted byte; returns 1 when a hash is due.
    function automatic bit step_hash(input logic [7:0] b, output word_t h);
        h = '0;
        if (!in_string)
        begin
            acc_word  = seed_shadow;
            in_string = 1'b1;
        end
        if (b != 8'h00)
        begin
            acc_word = {acc_word[WORD_BITS-10:0], acc_word[WORD_BITS-1:WORD_BITS-9]}
                       + word_t'(b);
            return 1'b0;
        end
        h         = shift_mult_mix(acc_word ^ seed_shadow) + seed_shadow;
        in_string = 1'b0;
        acc_word  = '0;
        return 1'b1;
    endfunction

    task automatic add_row(input row_kind_t kind, input word_t value,
                           input bit checked, input word_t hash);
        stim_row_t r;
        r.kind    = kind;
        r.value   = value;
        r.checked = checked;
        r.hash    = hash;
        directed_rows.push_back(r);
    endtask

    task automatic send_byte(input logic [7:0] b, input bit eager);
        int unsigned gap;
        if (eager)
            gap = 0;
        else if (send_calm > 0)
        begin
            gap = 0;
            send_calm--;
        end
        else
        begin
            gap = $urandom_range(0, 8);
            if ($urandom_range(0, 15) == 0)
                send_calm = $urandom_range(10, 40);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        text_byte <= b;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    // Lets every pending hash come out, then waits a settle period for bytes still in flight.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_hashes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_seed(input word_t value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        seed_shadow = value;
    endtask

    task automatic send_string(input int unsigned len, input bit eager);
        word_t      h;
        logic [7:0] b;
        for (int unsigned k = 0; k <= len; k++)
        begin
            if (k == len)
                b = 8'h00;
            else
                case ($urandom_range(0, 9))
                    0: b = 8'hFF;
                    1: b = 8'h01;
                    default: b = 8'($urandom_range(1, 255));
                endcase
            send_byte(b, eager);
            if (step_hash(b, h))
                expected_hashes.push_back(h);
        end
    endtask

    // Result side: random stalls, and one long hold-off when the sender asks for it.
    initial
    begin
        recv_calm = 0;
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (long_hold)
            begin
                recv_hold = LONG_HOLD;
                long_hold = 1'b0;
            end
            else if (recv_calm > 0)
            begin
                recv_hold = 0;
                recv_calm--;
            end
            else
            begin
                recv_hold = $urandom_range(0, 8);
                if ($urandom_range(0, 15) == 0)
                    recv_calm = $urandom_range(10, 40);
            end
            if (recv_hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (recv_hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            if (expected_hashes.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("mismatch: unexpected hash_value %h", hash_value);
            end
            else
            begin
                recv_want = expected_hashes.pop_front();
                if (hash_value !== recv_want)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("mismatch: hash_value expected %h actual %h",
                                 recv_want, hash_value);
                end
            end
        end
    end

    initial
    begin
        rst_n       <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        text_byte   <= '0;
        seed_shadow = '0;
        acc_word    = '0;
        in_string   = 1'b0;
        fail_count  = 0;
        items_sent  = 0;
        send_calm   = 0;
        long_hold   = 1'b0;

        // An empty string right after reset hashes the zero seed alone.
        add_row(ROW_BYTE, 64'h00, 1'b1, NO_SEED_EMPTY_HASH);
        add_row(ROW_BYTE, 64'hFF, 1'b0, '0);
        add_row(ROW_BYTE, 64'h01, 1'b0, '0);
        add_row(ROW_BYTE, 64'h80, 1'b0, '0);
        add_row(ROW_BYTE, 64'h00, 1'b0, '0);
        // With an all-ones seed the empty string mixes zero and adds the seed.
        add_row(ROW_SEED, '1, 1'b0, '0);
        add_row(ROW_BYTE, 64'h00, 1'b1, ONES_SEED_EMPTY_HASH);
        add_row(ROW_BYTE, 64'hFF, 1'b0, '0);
        add_row(ROW_BYTE, 64'hFF, 1'b0, '0);
        add_row(ROW_BYTE, 64'hFF, 1'b0, '0);
        add_row(ROW_BYTE, 64'hFF, 1'b0, '0);
        add_row(ROW_BYTE, 64'h00, 1'b0, '0);
        // The seed changes mid-string: the accumulator keeps the old one.
        add_row(ROW_BYTE, 64'h41, 1'b0, '0);
        add_row(ROW_SEED, 64'h0123_4567_89AB_CDEF, 1'b0, '0);
        add_row(ROW_BYTE, 64'h42, 1'b0, '0);
        add_row(ROW_BYTE, 64'h00, 1'b0, '0);
        add_row(ROW_SEED, '0, 1'b0, '0);
        add_row(ROW_BYTE, 64'h55, 1'b0, '0);
        add_row(ROW_BYTE, 64'hAA, 1'b0, '0);
        add_row(ROW_BYTE, 64'h00, 1'b0, '0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_SEED)
            begin
                wait_idle();
                write_seed(directed_rows[i].value);
            end
            else
            begin
                send_byte(directed_rows[i].value[7:0], 1'b0);
                if (step_hash(directed_rows[i].value[7:0], row_hash))
                    expected_hashes.push_back(directed_rows[i].checked ?
                                              directed_rows[i].hash : row_hash);
            end
        end

        items_sent = 0;
        phase      = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            case (phase)
                0: phase_seed = '0;
                1: phase_seed = '1;
                2: phase_seed = 64'h8000_0000_0000_0000;
                3: phase_seed = 64'h1;
                default: phase_seed = {$urandom, $urandom};
            endcase
            wait_idle();
            write_seed(phase_seed);
            if (phase == 4)
            begin
                // Empty strings back to back while the result side holds off,
                // so the core fills up and stalls its input.
                long_hold = 1'b1;
                repeat (40) send_string(0, 1'b1);
            end
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS && items_sent < RANDOM_ITEMS)
            begin
                len_pick = $urandom_range(0, 9);
                if (len_pick < 7)
                    send_string($urandom_range(0, 12), 1'b0);
                else if (len_pick < 9)
                    send_string($urandom_range(13, 64), 1'b0);
                else
                    send_string(0, 1'b0);
            end
            phase++;
        end

        in_valid <= 1'b0;
        while (expected_hashes.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("** seeded_string_hash_rotate_mix_core: PASSED **");
        else
            $display("** seeded_string_hash_rotate_mix_core: FAILED **");
        $finish;
    end

endmodule
